>>> hdl/json_object_framer_defines.svh
// Assertion macros for the JSON object framer.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef JSON_OBJECT_FRAMER_DEFINES_SVH
`define JSON_OBJECT_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JOF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/jof_pkg.sv
// Package for the JSON object framer: item types, scan modes and characters.
// No dependencies; imported by json_object_framer, jof_frame_checker and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package jof_pkg;

    // Default saturation limit of the brace depth counter.
    localparam int unsigned MAX_DEPTH_DEFAULT = 255;

    // Characters that steer the scanner.
    localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    // Scanner position relative to the current object.
    typedef enum logic [1:0] {
        MODE_OUT = 2'd0,
        MODE_OBJ = 2'd1,
        MODE_STR = 2'd2,
        MODE_ESC = 2'd3
    } scan_mode_t;

    // One input item: a raw byte of the stream and its stream-end flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    // One result item: a byte of an object with its framing marks.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        object_first;
        logic        object_last;
        logic        truncated;
        logic [31:0] start_line;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/json_object_framer.sv
// JSON object framer, top level: cuts top-level objects out of a byte stream.
// Depends on jof_pkg and json_object_framer_defines.svh.
//
// The block takes one byte per clock while the output side keeps taking
// results, and gives at most one result per byte. Bytes outside an object
// are dropped and only their newlines are counted. Each object byte comes
// out with first/last marks and the 1-based line on which its object began;
// a stream end inside an object closes it as truncated. A byte passes an
// input register and then a result register. The scan mode, depth and line
// counters update when a byte leaves the input register.
`timescale 1ns / 1ps
`default_nettype none
`include "json_object_framer_defines.svh"

module json_object_framer
    import jof_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    // Input register.
    logic       stage_valid_reg;
    in_item_t   stage_item_reg;

    // Scanner state.
    scan_mode_t         mode_reg, mode_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [31:0]        newline_reg, newline_next;
    logic [31:0]        line_reg, line_next;

    // Result register.
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    logic       stage_fire;
    logic       emit;
    logic       first;
    logic       last;
    logic       trunc;
    logic [7:0] b;

    // The staged byte moves on when the result register is free or drained.
    assign stage_fire = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !stage_valid_reg || stage_fire;
    assign b          = stage_item_reg.data_byte;

    // Scanner update for the staged byte.
    always_comb
    begin
        mode_next    = mode_reg;
        depth_next   = depth_reg;
        newline_next = newline_reg;
        line_next    = line_reg;
        emit         = 1'b1;
        first        = 1'b0;
        last         = 1'b0;
        trunc        = 1'b0;

        unique case (mode_reg)
            MODE_OUT:
            begin
                if (b == CHAR_LBRACE)
                begin
                    line_next  = newline_reg + 32'd1;
                    depth_next = DEPTH_ONE;
                    mode_next  = MODE_OBJ;
                    first      = 1'b1;
                end
                else
                begin
                    emit = 1'b0;
                    if (b == CHAR_NEWLINE)
                    begin
                        newline_next = newline_reg + 32'd1;
                    end
                end
            end
            MODE_OBJ:
            begin
                if (b == CHAR_LBRACE)
                begin
                    if (depth_reg < DEPTH_MAX)
                    begin
                        depth_next = depth_reg + DEPTH_ONE;
                    end
                end
                else if (b == CHAR_RBRACE)
                begin
                    if (depth_reg <= DEPTH_ONE)
                    begin
                        depth_next = '0;
                        mode_next  = MODE_OUT;
                        last       = 1'b1;
                    end
                    else
                    begin
                        depth_next = depth_reg - DEPTH_ONE;
                    end
                end
                else if (b == CHAR_QUOTE)
                begin
                    mode_next = MODE_STR;
                end
                else if (b == CHAR_NEWLINE)
                begin
                    newline_next = newline_reg + 32'd1;
                end
            end
            MODE_STR:
            begin
                if (b == CHAR_QUOTE)
                begin
                    mode_next = MODE_OBJ;
                end
                else if (b == CHAR_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else if (b == CHAR_NEWLINE)
                begin
                    newline_next = newline_reg + 32'd1;
                end
            end
            MODE_ESC:
            begin
                // The escaped byte is taken as is, even a newline.
                mode_next = MODE_STR;
            end
            default:
            begin
                mode_next = MODE_OUT;
            end
        endcase

        // A stream end inside an object closes it as truncated.
        if (emit && stage_item_reg.stream_end && !last)
        begin
            last       = 1'b1;
            trunc      = 1'b1;
            mode_next  = MODE_OUT;
            depth_next = '0;
        end
    end

    // Input register: control with reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= in_item;
        end
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OUT;
            depth_reg   <= '0;
            newline_reg <= '0;
            line_reg    <= '0;
        end
        else if (stage_fire)
        begin
            mode_reg    <= mode_next;
            depth_reg   <= depth_next;
            newline_reg <= newline_next;
            line_reg    <= line_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && emit)
        begin
            out_item_reg.out_byte     <= b;
            out_item_reg.object_first <= first;
            out_item_reg.object_last  <= last;
            out_item_reg.truncated    <= trunc;
            out_item_reg.start_line   <= line_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks on the scanner and the result marks.
    `JOF_ASSERT_IMPL(a_depth_matches_mode, 1'b1,
        ((mode_reg != MODE_OUT) == (depth_reg != '0)),
        "brace depth disagrees with scan mode")
    `JOF_ASSERT_IMPL(a_trunc_has_last, out_valid_reg,
        (!out_item_reg.truncated || out_item_reg.object_last),
        "truncated result without last mark")
    `JOF_ASSERT_NEXT(a_newline_step, 1'b1,
        ((newline_reg == $past(newline_reg)) ||
         (newline_reg == $past(newline_reg) + 32'd1)),
        "newline counter moved by more than one")

endmodule

`default_nettype wire

>>> verif/jof_frame_checker.sv
// Checker for the JSON object framer: predicts the framed bytes and compares them.
// Depends on jof_pkg; instantiated by tb_top beside the block and watches both channels.
`timescale 1ns / 1ps

module jof_frame_checker
    import jof_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_ready,
    input  in_item_t   in_item,
    input  wire logic  out_valid,
    input  wire logic  out_ready,
    input  out_item_t  out_item,
    output int unsigned mismatch_count,
    output int unsigned bytes_pending
);

    // Private copy of the scanner state.
    scan_mode_t  mode;
    int unsigned depth;
    logic [31:0] newlines;
    logic [31:0] object_line;

    // Framed bytes still owed by the block, oldest first.
    out_item_t   expected_frames[$];
    out_item_t   want;

    // Advance the scanner by one byte and queue the framed byte, if any.
    task automatic frame_byte(input in_item_t it);
        out_item_t r;
        logic      emit;
        r          = '0;
        r.out_byte = it.data_byte;
        emit       = 1'b1;
        case (mode)
            MODE_OUT:
            begin
                if (it.data_byte == CHAR_LBRACE)
                begin
                    object_line    = newlines + 32'd1;
                    depth          = 1;
                    mode           = MODE_OBJ;
                    r.object_first = 1'b1;
                end
                else
                begin
                    // Bytes between objects only advance the line count.
                    if (it.data_byte == CHAR_NEWLINE)
                        newlines = newlines + 32'd1;
                    emit = 1'b0;
                end
            end
            MODE_OBJ:
            begin
                if (it.data_byte == CHAR_LBRACE)
                begin
                    // The depth sticks at its ceiling.
                    if (depth < MAX_DEPTH)
                        depth++;
                end
                else if (it.data_byte == CHAR_RBRACE)
                begin
                    if (depth > 0)
                        depth--;
                    if (depth == 0)
                    begin
                        mode          = MODE_OUT;
                        r.object_last = 1'b1;
                    end
                end
                else if (it.data_byte == CHAR_QUOTE)
                    mode = MODE_STR;
                else if (it.data_byte == CHAR_NEWLINE)
                    newlines = newlines + 32'd1;
            end
            MODE_STR:
            begin
                if (it.data_byte == CHAR_QUOTE)
                    mode = MODE_OBJ;
                else if (it.data_byte == CHAR_BACKSLASH)
                    mode = MODE_ESC;
                else if (it.data_byte == CHAR_NEWLINE)
                    newlines = newlines + 32'd1;
            end
            default:
            begin
                // The escaped byte is taken as is, even a newline.
                mode = MODE_STR;
            end
        endcase
        if (emit)
        begin
            // A stream end inside an object cuts it off, unless it just closed.
            if (it.stream_end && !r.object_last)
            begin
                r.object_last = 1'b1;
                r.truncated   = 1'b1;
                mode          = MODE_OUT;
                depth         = 0;
            end
            r.start_line = object_line;
            expected_frames.insert(expected_frames.size(), r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Predict on every accepted input item and compare every accepted result item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode           = MODE_OUT;
            depth          = 0;
            newlines       = '0;
            object_line    = '0;
            mismatch_count = 0;
            bytes_pending  = 0;
            expected_frames.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                frame_byte(in_item);
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("unexpected result item: out_byte 0x%0h", out_item.out_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("out_byte", want.out_byte, out_item.out_byte);
                    check_field("object_first", want.object_first, out_item.object_first);
                    check_field("object_last", want.object_last, out_item.object_last);
                    check_field("truncated", want.truncated, out_item.truncated);
                    check_field("start_line", want.start_line, out_item.start_line);
                end
            end
            bytes_pending = expected_frames.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the JSON object framer: clock, reset, byte stimulus and verdict.
// Depends on jof_pkg, json_object_framer and jof_frame_checker.
`timescale 1ns / 1ps

module tb_top;
    import jof_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    int unsigned mismatch_count;
    int unsigned bytes_pending;
    int unsigned cycle_count;
    int unsigned object_bytes;
    bit          idle_en;
    bit          hold_req;
    in_item_t    byte_stream[$];

    json_object_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    jof_frame_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending)
    );

    // 4 ns clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: a hung run ends as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit fin);
        in_item_t it;
        it.data_byte  = b;
        it.stream_end = fin;
        byte_stream.insert(byte_stream.size(), it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    // Offer every queued byte, with random gaps before some of them.
    task automatic send_stream();
        int unsigned gap;
        while (byte_stream.size() > 0)
        begin
            gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            in_valid <= 1'b1;
            in_item  <= byte_stream.pop_front();
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    // A random, well-formed object; some end the stream early or on the last brace.
    task automatic add_object(input int unsigned max_len);
        logic [7:0]  body[$];
        logic [7:0]  b;
        int unsigned level;
        int unsigned pick;
        int unsigned n;
        int unsigned ending;
        int unsigned cut;
        body.insert(body.size(), CHAR_LBRACE);
        level = 1;
        while (level > 0)
        begin
            pick = (body.size() >= max_len) ? 1 : $urandom_range(0, 9);
            case (pick)
                0:
                begin
                    if (level < 4)
                    begin
                        body.insert(body.size(), CHAR_LBRACE);
                        level++;
                    end
                end
                1, 2:
                begin
                    body.insert(body.size(), CHAR_RBRACE);
                    level--;
                end
                3, 4:
                begin
                    // String with random content and escapes of any byte.
                    body.insert(body.size(), CHAR_QUOTE);
                    n = $urandom_range(0, 6);
                    repeat (n)
                    begin
                        b = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 4) == 0)
                            body.insert(body.size(), CHAR_BACKSLASH);
                        else if (b == CHAR_QUOTE || b == CHAR_BACKSLASH)
                            b = "_";
                        body.insert(body.size(), b);
                    end
                    body.insert(body.size(), CHAR_QUOTE);
                end
                5:
                begin
                    b = 8'("0" + $urandom_range(0, 9));
                    body.insert(body.size(), b);
                end
                6: body.insert(body.size(), CHAR_NEWLINE);
                7: body.insert(body.size(), ":");
                8: body.insert(body.size(), ",");
                default: body.insert(body.size(), " ");
            endcase
        end
        ending = $urandom_range(0, 9);
        cut    = (ending == 0) ? $urandom_range(0, body.size() - 1) : body.size() - 1;
        for (int i = 0; i <= cut; i++)
            push_byte(body[i], (i == cut) && (ending <= 1));
        object_bytes += cut + 1;
    endtask

    // Bytes between objects: newlines, stray closing braces and random bytes other than an opening brace.
    task automatic add_noise();
        int unsigned n;
        int unsigned pick;
        logic [7:0]  b;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                b = CHAR_NEWLINE;
            else if (pick == 4)
                b = CHAR_RBRACE;
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CHAR_LBRACE)
                    b = CHAR_NEWLINE;
            end
            push_byte(b, (i == n - 1) && ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned goal;
        goal = object_bytes + count;
        while (object_bytes < goal)
        begin
            if ($urandom_range(0, 2) == 0)
                add_noise();
            add_object($urandom_range(2, 40));
        end
        send_stream();
    endtask

    // Main sequence.
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        idle_en      = 1'b1;
        hold_req     = 1'b0;
        object_bytes = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: bytes outside, nesting, strings with escapes, stream ends.
        push_text("\n");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("{\n\"a{}\\\n\\\"\n\"{");
        push_byte(8'hFF, 1'b0);
        push_text("}}");
        push_byte(CHAR_LBRACE, 1'b1);
        push_text("{\"");
        push_byte(CHAR_BACKSLASH, 1'b1);
        push_text("{");
        push_byte(CHAR_RBRACE, 1'b1);
        push_byte("x", 1'b1);
        send_stream();

        // Nesting past the depth ceiling, so the object closes early.
        for (int i = 0; i < 260; i++)
            push_byte(CHAR_LBRACE, 1'b0);
        push_text("\"x\"");
        for (int i = 0; i < 256; i++)
            push_byte(CHAR_RBRACE, 1'b0);
        push_text("\n");
        send_stream();

        // Long output hold-off while a long object keeps coming in.
        idle_en  = 1'b0;
        hold_req = 1'b1;
        push_byte(CHAR_LBRACE, 1'b0);
        for (int i = 0; i < 78; i++)
            push_byte((i % 10 == 9) ? CHAR_NEWLINE : "a", 1'b0);
        push_byte(CHAR_RBRACE, 1'b0);
        send_stream();
        idle_en = 1'b1;

        // Random traffic with idling, then a final stretch without it.
        run_random(250);
        idle_en = 1'b0;
        run_random(100);
        @(negedge clk);
        in_valid <= 1'b0;

        while (bytes_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/jof_pkg.sv
hdl/json_object_framer.sv
verif/jof_frame_checker.sv
verif/tb_top.sv
